@@ design/was_pkg.sv @@
`default_nettype none
package was_pkg;

    localparam int MAX_ENTRIES = 32;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_CLEAR   = 3'd1;
    localparam logic [2:0] CMD_APPEND  = 3'd2;
    localparam logic [2:0] CMD_QUERY   = 3'd3;
    localparam logic [2:0] CMD_REFRESH = 3'd4;

    localparam logic [2:0] REG_SLEEP_EN   = 3'd0;
    localparam logic [2:0] REG_SLEEP_DAYS = 3'd1;
    localparam logic [2:0] REG_BED_HOUR   = 3'd2;
    localparam logic [2:0] REG_BED_MIN    = 3'd3;
    localparam logic [2:0] REG_WAKE_HOUR  = 3'd4;
    localparam logic [2:0] REG_WAKE_MIN   = 3'd5;
    localparam logic [2:0] REG_WKND_OFF   = 3'd6;
    localparam logic [2:0] REG_TIMEOUT    = 3'd7;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_NORMAL = 2'd1;
    localparam logic [1:0] KIND_BED    = 2'd2;
    localparam logic [1:0] KIND_WAKE   = 2'd3;

    localparam logic [15:0] TIMEOUT_RESET = 16'd60000;
    localparam logic [7:0]  NONE_TIME     = 8'hff;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_RING  = 2'd1,
        MODE_CHECK = 2'd2
    } mode_t;

    typedef struct packed {
        logic [6:0] days;
        logic [7:0] hour;
        logic [7:0] minute;
    } entry_t;

    typedef struct packed {
        logic        sleep_en;
        logic [6:0]  sleep_days;
        logic [7:0]  bed_hour;
        logic [7:0]  bed_minute;
        logic [7:0]  wake_hour;
        logic [7:0]  wake_minute;
        logic        weekends_off;
        logic [15:0] timeout;
    } cfg_t;

endpackage
`default_nettype wire

@@ design/was_cfg.sv @@
`default_nettype none
module was_cfg
    import was_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [31:0] wr_data,
    output cfg_t             cfg
);
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{timeout: TIMEOUT_RESET, default: '0};
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SLEEP_EN:   cfg_reg.sleep_en     <= wr_data[0];
                REG_SLEEP_DAYS: cfg_reg.sleep_days   <= wr_data[6:0];
                REG_BED_HOUR:   cfg_reg.bed_hour     <= wr_data[7:0];
                REG_BED_MIN:    cfg_reg.bed_minute   <= wr_data[7:0];
                REG_WAKE_HOUR:  cfg_reg.wake_hour    <= wr_data[7:0];
                REG_WAKE_MIN:   cfg_reg.wake_minute  <= wr_data[7:0];
                REG_WKND_OFF:   cfg_reg.weekends_off <= wr_data[0];
                REG_TIMEOUT:    cfg_reg.timeout      <= wr_data[15:0];
                default:        cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule
`default_nettype wire

@@ design/was_table.sv @@
`default_nettype none
module was_table
    import was_pkg::*;
#(
    parameter int AW = 5
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  entry_t             wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output entry_t             rd_data
);
    entry_t mem [2**AW];
    entry_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;
endmodule
`default_nettype wire

@@ design/weekly_alarm_scheduler_top.sv @@
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_stall   | command .. query_position
// out     | output    | out_valid/out_stall | alarm_fire .. today_has_alarm
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
// One item at a time. Tick, clear and refresh go straight to ST_DONE and ST_OUT;
// append, query and the search step walk the table through one read port,
// one entry per cycle, in up to two passes.
// Reset clears all control state; the table holds garbage until appended.
// in_stall stays high from acceptance until the result word is taken;
// out_stall holds the result word in place.
`default_nettype none
module weekly_alarm_scheduler_top
    import was_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  command,
    input  wire logic [2:0]  day_of_week,
    input  wire logic [4:0]  now_hour,
    input  wire logic [5:0]  now_minute,
    input  wire logic [31:0] now_ms,
    input  wire logic        notifier_idle,
    input  wire logic        link_authorized,
    input  wire logic        update_active,
    input  wire logic [6:0]  entry_days,
    input  wire logic [7:0]  entry_hour,
    input  wire logic [7:0]  entry_minute,
    input  wire logic [7:0]  query_position,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             alarm_fire,
    output logic [1:0]       alarm_kind,
    output logic [7:0]       alarm_hour,
    output logic [7:0]       alarm_minute,
    output logic             next_valid,
    output logic [4:0]       next_hour,
    output logic [5:0]       next_minute,
    output logic [7:0]       display_hour,
    output logic [7:0]       display_minute,
    output logic [4:0]       query_result,
    output logic [5:0]       entry_count,
    output logic             today_has_alarm,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_ENTRIES);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_WALK = 5'b00010,
        ST_PICK = 5'b00100,
        ST_DONE = 5'b01000,
        ST_OUT  = 5'b10000
    } st_t;

    cfg_t cfg;
    was_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .wr_en(cfg_valid && cfg_ready),
        .wr_index(cfg_index), .wr_data(cfg_data), .cfg(cfg)
    );
    assign cfg_ready = 1'b1;

    logic          tw_en;
    logic [AW-1:0] tw_addr, tr_addr;
    entry_t        tw_data, tr_data;
    was_table #(.AW(AW)) u_table (
        .clk(clk), .wr_en(tw_en), .wr_addr(tw_addr), .wr_data(tw_data),
        .rd_addr(tr_addr), .rd_data(tr_data)
    );

    st_t st_reg, st_next;
    // item latched
    logic [2:0]  cmd_reg;
    logic [2:0]  dow_reg;
    logic [4:0]  hr_reg;
    logic [5:0]  mn_reg;
    logic [7:0]  qpos_reg;
    // walk
    logic [CW-1:0] idx_reg, idx_next;     // address issued
    logic          rv_reg;                 // read data valid
    logic          stop_reg, stop_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] sel_reg, sel_next;
    logic          first_reg, first_next;
    logic          pass2_reg;
    logic [CW-1:0] pick_reg;
    // architectural state
    logic [CW-1:0] count_reg, count_next;
    mode_t         mode_reg, mode_next;
    logic [31:0]   rstart_reg, rstart_next;
    logic          av_reg, av_next;
    logic [4:0]    ah_reg, ah_next;
    logic [5:0]    am_reg, am_next;
    logic          bed_reg, bed_next, wake_reg, wake_next;
    logic [7:0]    sh_reg, sh_next, sm_reg, sm_next;
    logic          daily_reg, daily_next;
    logic          fire_reg, fire_next;
    logic [1:0]    kind_reg, kind_next;
    logic [7:0]    fh_reg, fh_next, fm_reg, fm_next;
    logic [4:0]    qres_reg, qres_next;

    logic [6:0] day;
    logic       hit, bad, later, walk_end, accept;
    logic [31:0] elapsed;

    always_comb
    begin
        day = 7'(8'd1 << dow_reg);
    end
    assign hit   = (tr_data.days & day) != 7'd0;
    assign bad   = (tr_data.hour >= 8'd24) || (tr_data.minute >= 8'd60);
    assign later = (tr_data.hour > {3'd0, hr_reg}) ||
                   (tr_data.hour == {3'd0, hr_reg} && tr_data.minute > {2'd0, mn_reg});
    assign elapsed = now_ms - rstart_reg;
    assign walk_end = (idx_reg >= count_reg) && !rv_reg;

    assign in_stall  = (st_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = (st_reg == ST_OUT);
    assign tr_addr   = idx_reg[AW-1:0];
    assign tw_addr   = count_reg[AW-1:0];
    assign tw_data   = '{days: entry_days, hour: entry_hour, minute: entry_minute};
    assign tw_en     = accept && command == CMD_APPEND && count_reg < MAXC;

    always_comb
    begin
        st_next = st_reg;   idx_next = idx_reg;   stop_next = stop_reg;
        total_next = total_reg; sel_next = sel_reg; first_next = first_reg;
        count_next = count_reg; mode_next = mode_reg; rstart_next = rstart_reg;
        av_next = av_reg; ah_next = ah_reg; am_next = am_reg;
        bed_next = bed_reg; wake_next = wake_reg;
        sh_next = sh_reg; sm_next = sm_reg; daily_next = daily_reg;
        fire_next = fire_reg; kind_next = kind_reg; fh_next = fh_reg;
        fm_next = fm_reg; qres_next = qres_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fire_next = 1'b0; kind_next = KIND_NONE; fh_next = '0;
                    fm_next = '0; qres_next = '0;
                    idx_next = '0; stop_next = 1'b0; total_next = '0;
                    sel_next = '0; first_next = 1'b0;
                    st_next = ST_DONE;
                    case (command)
                        CMD_TICK:
                        begin
                            if (!update_active)
                            begin
                                case (mode_reg)
                                    MODE_IDLE:
                                    begin
                                        if (bed_reg && {3'd0, now_hour} == cfg.bed_hour &&
                                            {2'd0, now_minute} == cfg.bed_minute)
                                        begin
                                            bed_next = 1'b0; fire_next = 1'b1;
                                            kind_next = KIND_BED; fh_next = cfg.bed_hour;
                                            fm_next = cfg.bed_minute;
                                        end
                                        else if (wake_reg &&
                                            {3'd0, now_hour} == cfg.wake_hour &&
                                            {2'd0, now_minute} == cfg.wake_minute)
                                        begin
                                            wake_next = 1'b0; fire_next = 1'b1;
                                            kind_next = KIND_WAKE; fh_next = cfg.wake_hour;
                                            fm_next = cfg.wake_minute;
                                        end
                                        else if (av_reg && now_hour == ah_reg &&
                                            now_minute == am_reg)
                                        begin
                                            av_next = 1'b0; fire_next = 1'b1;
                                            kind_next = KIND_NORMAL;
                                            fh_next = {3'd0, ah_reg};
                                            fm_next = {2'd0, am_reg};
                                        end
                                        if (fire_next)
                                        begin
                                            mode_next = MODE_RING;
                                            rstart_next = now_ms;
                                        end
                                    end
                                    MODE_RING:
                                    begin
                                        if (notifier_idle || elapsed > {16'd0, cfg.timeout})
                                            mode_next = MODE_CHECK;
                                    end
                                    default:
                                    begin
                                        sh_next = NONE_TIME; sm_next = NONE_TIME;
                                        daily_next = 1'b0;
                                        av_next = 1'b0; ah_next = '0; am_next = '0;
                                        mode_next = MODE_IDLE;
                                        if (link_authorized &&
                                            !(cfg.weekends_off && day_of_week > 3'd4))
                                            st_next = ST_WALK;
                                    end
                                endcase
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0; sh_next = NONE_TIME; sm_next = NONE_TIME;
                            mode_next = MODE_CHECK;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg < MAXC)
                                count_next = count_reg + CW'(1);
                            sh_next = NONE_TIME; sm_next = NONE_TIME;
                            mode_next = MODE_CHECK;
                            st_next = ST_WALK;
                        end
                        CMD_QUERY:
                        begin
                            sh_next = NONE_TIME; sm_next = NONE_TIME;
                            st_next = ST_WALK;
                        end
                        CMD_REFRESH:
                        begin
                            bed_next = 1'b0; wake_next = 1'b0;
                            if (cfg.sleep_en && (cfg.sleep_days &
                                7'(8'd1 << day_of_week)) != 7'd0)
                            begin
                                bed_next = 1'b1; wake_next = 1'b1;
                            end
                        end
                        default: st_next = ST_DONE;
                    endcase
                end
            end
            ST_WALK, ST_PICK:
            begin
                if (!stop_reg && idx_reg < count_reg)
                    idx_next = idx_reg + CW'(1);
                if (rv_reg && !stop_reg)
                begin
                    case (cmd_reg)
                        CMD_APPEND:
                            if (hit)
                            begin
                                sh_next = tr_data.hour; sm_next = tr_data.minute;
                                stop_next = 1'b1;
                            end
                        CMD_QUERY:
                            if (!pass2_reg)
                            begin
                                if (hit) total_next = total_reg + CW'(1);
                            end
                            else if (hit)
                            begin
                                if (sel_reg == pick_reg)
                                begin
                                    stop_next = 1'b1;
                                    if (!bad)
                                    begin
                                        sh_next = tr_data.hour; sm_next = tr_data.minute;
                                        qres_next = pick_reg[4:0];
                                    end
                                end
                                sel_next = sel_reg + CW'(1);
                            end
                        default:
                            if (bad)
                                stop_next = 1'b1;
                            else if (hit)
                            begin
                                daily_next = 1'b1;
                                if (!first_reg)
                                begin
                                    first_next = 1'b1;
                                    sh_next = tr_data.hour; sm_next = tr_data.minute;
                                end
                                if (later)
                                begin
                                    av_next = 1'b1; ah_next = tr_data.hour[4:0];
                                    am_next = tr_data.minute[5:0];
                                    stop_next = 1'b1;
                                end
                            end
                    endcase
                end
                if (stop_next || walk_end)
                begin
                    if (cmd_reg == CMD_QUERY && !pass2_reg && total_next != '0)
                    begin
                        st_next = ST_PICK;
                        idx_next = '0;
                    end
                    else
                        st_next = ST_DONE;
                end
            end
            ST_DONE: st_next = ST_OUT;
            ST_OUT:  if (!out_stall) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command; dow_reg <= day_of_week; hr_reg <= now_hour;
            mn_reg <= now_minute; qpos_reg <= query_position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE; idx_reg <= '0; rv_reg <= 1'b0;
            stop_reg <= 1'b0; total_reg <= '0; sel_reg <= '0; first_reg <= 1'b0;
            pass2_reg <= 1'b0; pick_reg <= '0;
            count_reg <= '0; mode_reg <= MODE_CHECK; rstart_reg <= '0;
            av_reg <= 1'b0; ah_reg <= '0; am_reg <= '0;
            bed_reg <= 1'b0; wake_reg <= 1'b0;
            sh_reg <= NONE_TIME; sm_reg <= NONE_TIME; daily_reg <= 1'b0;
            fire_reg <= 1'b0; kind_reg <= KIND_NONE; fh_reg <= '0; fm_reg <= '0;
            qres_reg <= '0;
        end
        else
        begin
            st_reg <= st_next; total_reg <= total_next; sel_reg <= sel_next;
            first_reg <= first_next;
            count_reg <= count_next; mode_reg <= mode_next; rstart_reg <= rstart_next;
            av_reg <= av_next; ah_reg <= ah_next; am_reg <= am_next;
            bed_reg <= bed_next; wake_reg <= wake_next;
            sh_reg <= sh_next; sm_reg <= sm_next; daily_reg <= daily_next;
            fire_reg <= fire_next; kind_reg <= kind_next; fh_reg <= fh_next;
            fm_reg <= fm_next; qres_reg <= qres_next;
            idx_reg <= idx_next;
            stop_reg <= stop_next;
            // a read is valid next cycle if issued in range while the walk continues
            rv_reg <= (st_reg == ST_WALK || st_reg == ST_PICK) && st_next == st_reg &&
                      !stop_next && idx_reg < count_reg;
            if (st_reg == ST_IDLE)
                pass2_reg <= 1'b0;
            else if (st_next == ST_PICK && st_reg == ST_WALK)
            begin
                // second pass: restart the walk, a position at or past today's count picks the first match
                pass2_reg <= 1'b1;
                pick_reg <= ({1'b0, qpos_reg} >= 9'(total_next)) ? '0 : CW'(qpos_reg);
            end
        end
    end

    assign alarm_fire      = fire_reg;
    assign alarm_kind      = kind_reg;
    assign alarm_hour      = fh_reg;
    assign alarm_minute    = fm_reg;
    assign next_valid      = av_reg;
    assign next_hour       = av_reg ? ah_reg : 5'd0;
    assign next_minute     = av_reg ? am_reg : 6'd0;
    assign display_hour    = sh_reg;
    assign display_minute  = sm_reg;
    assign query_result    = qres_reg;
    assign entry_count     = 6'(count_reg);
    assign today_has_alarm = daily_reg;
endmodule
`default_nettype wire

@@ design/was_checker.sv @@
`default_nettype none
module was_checker
    import was_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       alarm_fire,
    input wire logic [1:0] alarm_kind,
    input wire logic [5:0] entry_count,
    input wire logic       next_valid,
    input wire logic [4:0] next_hour
);
    a_fire_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (alarm_fire == (alarm_kind != KIND_NONE)))
        else $error("fire and kind disagree");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= 6'd32)
        else $error("count past limit");
    a_next_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !next_valid) |-> next_hour == 5'd0)
        else $error("idle next not zero");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(entry_count))
        else $error("stalled result changed");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");
endmodule

bind weekly_alarm_scheduler_top was_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .alarm_fire(alarm_fire),
    .alarm_kind(alarm_kind), .entry_count(entry_count), .next_valid(next_valid),
    .next_hour(next_hour)
);
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import was_pkg::*;

    localparam int  TABLE_DEPTH = 32;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  SETTLE      = 100;
    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

    typedef struct {
        logic [2:0]  command;
        logic [2:0]  dow;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [31:0] ms;
        logic        notifier_idle;
        logic        link_ok;
        logic        updating;
        logic [6:0]  e_days;
        logic [7:0]  e_hour;
        logic [7:0]  e_minute;
        logic [7:0]  qpos;
    } cmd_word_t;

    typedef struct {
        logic        fire;
        logic [1:0]  kind;
        logic [7:0]  f_hour;
        logic [7:0]  f_minute;
        logic        nxt_valid;
        logic [4:0]  nxt_hour;
        logic [5:0]  nxt_minute;
        logic [7:0]  disp_hour;
        logic [7:0]  disp_minute;
        logic [4:0]  qres;
        logic [5:0]  count;
        logic        has_today;
    } status_word_t;

    class alarm_scoreboard;
        cfg_t         cfg;
        entry_t       alarms[TABLE_DEPTH];
        int           count;
        mode_t        mode;
        logic [31:0]  ring_start;
        logic         arm_v;
        logic [4:0]   arm_h;
        logic [5:0]   arm_m;
        logic         bed_due, wake_due;
        logic [7:0]   disp_h, disp_m;
        logic         today_flag;
        status_word_t pending[$];
        int           errors, checked, fires;

        function new();
            cfg = '0;
            cfg.timeout = TIMEOUT_RESET;
            count = 0;
            mode = MODE_CHECK;
            ring_start = '0;
            arm_v = 0; arm_h = '0; arm_m = '0;
            bed_due = 0; wake_due = 0;
            disp_h = NONE_TIME; disp_m = NONE_TIME;
            today_flag = 0;
            errors = 0; checked = 0; fires = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                REG_SLEEP_EN:   cfg.sleep_en = d[0];
                REG_SLEEP_DAYS: cfg.sleep_days = d[6:0];
                REG_BED_HOUR:   cfg.bed_hour = d[7:0];
                REG_BED_MIN:    cfg.bed_minute = d[7:0];
                REG_WAKE_HOUR:  cfg.wake_hour = d[7:0];
                REG_WAKE_MIN:   cfg.wake_minute = d[7:0];
                REG_WKND_OFF:   cfg.weekends_off = d[0];
                REG_TIMEOUT:    cfg.timeout = d[15:0];
                default: ;
            endcase
        endfunction

        function logic [6:0] day_mask(logic [2:0] dow);
            logic [7:0] b;
            b = 8'd1 << dow;
            return b[6:0];
        endfunction

        function void find_next(cmd_word_t w);
            logic [6:0] dm;
            logic       first;
            dm = day_mask(w.dow);
            first = 0;
            disp_h = NONE_TIME; disp_m = NONE_TIME;
            today_flag = 0;
            arm_v = 0; arm_h = '0; arm_m = '0;
            if (!w.link_ok || (cfg.weekends_off && w.dow > 3'd4))
                return;
            for (int i = 0; i < count; i++) begin
                if (alarms[i].hour >= 8'd24 || alarms[i].minute >= 8'd60)
                    break;
                if ((alarms[i].days & dm) != 0) begin
                    today_flag = 1;
                    if (!first) begin
                        first = 1;
                        disp_h = alarms[i].hour;
                        disp_m = alarms[i].minute;
                    end
                    if (alarms[i].hour > w.hour ||
                        (alarms[i].hour == w.hour && alarms[i].minute > w.minute)) begin
                        arm_v = 1;
                        arm_h = alarms[i].hour[4:0];
                        arm_m = alarms[i].minute[5:0];
                        return;
                    end
                end
            end
        endfunction

        // advance the model by one accepted command word
        function void note_command(cmd_word_t w);
            status_word_t r;
            logic [6:0] dm;
            int total, pick, sel, hit;
            r = '{default: '0};
            dm = day_mask(w.dow);
            case (w.command)
                CMD_TICK:
                    if (!w.updating) begin
                        if (mode == MODE_IDLE) begin
                            if (bed_due && w.hour == cfg.bed_hour && w.minute == cfg.bed_minute)
                            begin
                                bed_due = 0;
                                r.fire = 1; r.kind = KIND_BED;
                                r.f_hour = cfg.bed_hour; r.f_minute = cfg.bed_minute;
                            end
                            else if (wake_due && w.hour == cfg.wake_hour &&
                                     w.minute == cfg.wake_minute)
                            begin
                                wake_due = 0;
                                r.fire = 1; r.kind = KIND_WAKE;
                                r.f_hour = cfg.wake_hour; r.f_minute = cfg.wake_minute;
                            end
                            else if (arm_v && w.hour == arm_h && w.minute == arm_m)
                            begin
                                arm_v = 0;
                                r.fire = 1; r.kind = KIND_NORMAL;
                                r.f_hour = arm_h; r.f_minute = arm_m;
                            end
                            if (r.fire)
                            begin
                                mode = MODE_RING;
                                ring_start = w.ms;
                            end
                        end
                        else if (mode == MODE_RING) begin
                            if (w.notifier_idle || (w.ms - ring_start) > {16'd0, cfg.timeout})
                                mode = MODE_CHECK;
                        end
                        else begin
                            find_next(w);
                            mode = MODE_IDLE;
                        end
                    end
                CMD_CLEAR:
                begin
                    count = 0;
                    disp_h = NONE_TIME; disp_m = NONE_TIME;
                    mode = MODE_CHECK;
                end
                CMD_APPEND:
                begin
                    if (count < TABLE_DEPTH)
                    begin
                        alarms[count] = '{days: w.e_days, hour: w.e_hour, minute: w.e_minute};
                        count++;
                    end
                    disp_h = NONE_TIME; disp_m = NONE_TIME;
                    for (int i = 0; i < count; i++)
                        if ((alarms[i].days & dm) != 0)
                        begin
                            disp_h = alarms[i].hour;
                            disp_m = alarms[i].minute;
                            break;
                        end
                    mode = MODE_CHECK;
                end
                CMD_QUERY:
                begin
                    disp_h = NONE_TIME; disp_m = NONE_TIME;
                    total = 0;
                    for (int i = 0; i < count; i++)
                        if ((alarms[i].days & dm) != 0)
                            total++;
                    if (total != 0)
                    begin
                        pick = (w.qpos >= total) ? 0 : w.qpos;
                        sel = 0;
                        hit = -1;
                        for (int i = 0; i < count; i++)
                            if ((alarms[i].days & dm) != 0)
                            begin
                                if (sel == pick)
                                begin
                                    hit = i;
                                    break;
                                end
                                sel++;
                            end
                        if (hit >= 0 && alarms[hit].hour < 8'd24 && alarms[hit].minute < 8'd60)
                        begin
                            disp_h = alarms[hit].hour;
                            disp_m = alarms[hit].minute;
                            r.qres = pick[4:0];
                        end
                    end
                end
                CMD_REFRESH:
                begin
                    bed_due = cfg.sleep_en && ((cfg.sleep_days & dm) != 0);
                    wake_due = bed_due;
                end
                default: ;
            endcase
            r.nxt_valid = arm_v;
            r.nxt_hour = arm_v ? arm_h : '0;
            r.nxt_minute = arm_v ? arm_m : '0;
            r.disp_hour = disp_h;
            r.disp_minute = disp_m;
            r.count = count[5:0];
            r.has_today = today_flag;
            pending.push_back(r);
        endfunction

        function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v)
            begin
                errors++;
                $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_status(status_word_t a);
            status_word_t e;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t unexpected status word: expected none actual count %0d",
                         $time, a.count);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (a.fire === 1'b1)
                fires++;
            cmp("alarm_fire", e.fire, a.fire);
            cmp("alarm_kind", e.kind, a.kind);
            cmp("alarm_hour", e.f_hour, a.f_hour);
            cmp("alarm_minute", e.f_minute, a.f_minute);
            cmp("next_valid", e.nxt_valid, a.nxt_valid);
            cmp("next_hour", e.nxt_hour, a.nxt_hour);
            cmp("next_minute", e.nxt_minute, a.nxt_minute);
            cmp("display_hour", e.disp_hour, a.disp_hour);
            cmp("display_minute", e.disp_minute, a.disp_minute);
            cmp("query_result", e.qres, a.qres);
            cmp("entry_count", e.count, a.count);
            cmp("today_has_alarm", e.has_today, a.has_today);
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [2:0]  command = '0;
    logic [2:0]  day_of_week = '0;
    logic [4:0]  now_hour = '0;
    logic [5:0]  now_minute = '0;
    logic [31:0] now_ms = '0;
    logic        notifier_idle = 0;
    logic        link_authorized = 0;
    logic        update_active = 0;
    logic [6:0]  entry_days = '0;
    logic [7:0]  entry_hour = '0;
    logic [7:0]  entry_minute = '0;
    logic [7:0]  query_position = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic        alarm_fire;
    logic [1:0]  alarm_kind;
    logic [7:0]  alarm_hour, alarm_minute;
    logic        next_valid;
    logic [4:0]  next_hour;
    logic [5:0]  next_minute;
    logic [7:0]  display_hour, display_minute;
    logic [4:0]  query_result;
    logic [5:0]  entry_count;
    logic        today_has_alarm;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    weekly_alarm_scheduler_top dut (.*);

    always #4 clk = ~clk;

    alarm_scoreboard sb = new();
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          sent = 0;
    int          cycles = 0;
    logic [31:0] clock_ms = '0;
    logic [7:0]  hour_pool[4] = '{8'd0, 8'd8, 8'd9, 8'd23};
    logic [7:0]  min_pool[4] = '{8'd0, 8'd1, 8'd2, 8'd59};

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words pending", cycles, sb.pending.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_command('{command, day_of_week, now_hour, now_minute, now_ms,
                              notifier_idle, link_authorized, update_active,
                              entry_days, entry_hour, entry_minute, query_position});
        if (rst_n && out_valid && !out_stall)
            sb.check_status('{alarm_fire, alarm_kind, alarm_hour, alarm_minute,
                              next_valid, next_hour, next_minute, display_hour,
                              display_minute, query_result, entry_count, today_has_alarm});
    end

    task automatic send_word(cmd_word_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        command <= w.command;
        day_of_week <= w.dow;
        now_hour <= w.hour;
        now_minute <= w.minute;
        now_ms <= w.ms;
        notifier_idle <= w.notifier_idle;
        link_authorized <= w.link_ok;
        update_active <= w.updating;
        entry_days <= w.e_days;
        entry_hour <= w.e_hour;
        entry_minute <= w.e_minute;
        query_position <= w.qpos;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic program_regs(logic [31:0] vals[8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1;
            cfg_index <= i[2:0];
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            sb.write_reg(i[2:0], vals[i]);
        end
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    function automatic cmd_word_t base_word(logic [2:0] c);
        cmd_word_t w;
        w = '{command: c, dow: 3'd1, hour: 5'd8, minute: 6'd0, ms: clock_ms,
              notifier_idle: 1, link_ok: 1, updating: 0, e_days: 7'h7f,
              e_hour: 8'd8, e_minute: 8'd1, qpos: 8'd0};
        return w;
    endfunction

    function automatic cmd_word_t random_word();
        cmd_word_t w;
        int sel;
        sel = $urandom_range(99);
        w.command = (sel < 55) ? CMD_TICK : (sel < 70) ? CMD_APPEND : (sel < 80) ? CMD_QUERY :
                    (sel < 92) ? CMD_REFRESH : (sel < 95) ? CMD_CLEAR :
                    3'($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED));
        w.dow = ($urandom_range(19) == 0) ? 3'd7 : 3'($urandom_range(6));
        if ($urandom_range(9) < 8)
        begin
            w.hour = hour_pool[$urandom_range(3)][4:0];
            w.minute = min_pool[$urandom_range(3)][5:0];
        end
        else
        begin
            w.hour = 5'($urandom_range(31));
            w.minute = 6'($urandom_range(63));
        end
        // mostly a running clock, sometimes large jumps to pass the ring timeout
        clock_ms = clock_ms + (($urandom_range(3) == 0) ? $urandom_range(70000) : $urandom_range(500));
        w.ms = ($urandom_range(19) == 0) ? $urandom() : clock_ms;
        w.notifier_idle = ($urandom_range(9) < 4);
        w.link_ok = ($urandom_range(9) != 0);
        w.updating = ($urandom_range(9) == 0);
        w.e_days = ($urandom_range(3) == 0) ? 7'h7f : 7'($urandom_range(127));
        if ($urandom_range(9) < 8)
        begin
            w.e_hour = hour_pool[$urandom_range(3)];
            w.e_minute = min_pool[$urandom_range(3)];
        end
        else
        begin
            w.e_hour = 8'($urandom_range(255));
            w.e_minute = 8'($urandom_range(255));
        end
        w.qpos = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(5));
        return w;
    endfunction

    function automatic void pool_regs(ref logic [31:0] v[8]);
        v[REG_SLEEP_EN] = 1;
        v[REG_SLEEP_DAYS] = $urandom_range(127);
        v[REG_BED_HOUR] = hour_pool[$urandom_range(3)];
        v[REG_BED_MIN] = min_pool[$urandom_range(3)];
        v[REG_WAKE_HOUR] = hour_pool[$urandom_range(3)];
        v[REG_WAKE_MIN] = min_pool[$urandom_range(3)];
        v[REG_WKND_OFF] = $urandom_range(1);
        v[REG_TIMEOUT] = $urandom_range(65535);
    endfunction

    initial
    begin
        logic [31:0] regs[8];
        cmd_word_t   w;
        int          idle_set[4];
        int          stall_set[4];

        idle_set  = '{0, 86, 0, 13};
        stall_set = '{0, 0, 86, 13};

        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset defaults first, then odd cases
        send_word(base_word(CMD_TICK));
        w = base_word(CMD_REFRESH); send_word(w);
        w = base_word(CMD_APPEND); w.e_hour = 8'd0; w.e_minute = 8'd0; send_word(w);
        w = base_word(CMD_APPEND); w.e_days = 7'd0; w.e_hour = 8'd9; send_word(w);
        w = base_word(CMD_APPEND); w.e_hour = 8'd9; w.e_minute = 8'd2; send_word(w);
        w = base_word(CMD_APPEND); w.e_hour = 8'hff; w.e_minute = 8'hff; send_word(w);
        w = base_word(CMD_APPEND); w.e_hour = 8'd23; w.e_minute = 8'd59; send_word(w);
        w = base_word(CMD_QUERY); send_word(w);
        w = base_word(CMD_QUERY); w.qpos = 8'd2; send_word(w);
        w = base_word(CMD_QUERY); w.qpos = 8'hff; send_word(w);
        w = base_word(CMD_QUERY); w.dow = 3'd7; send_word(w);
        w = base_word(CMD_TICK); w.hour = 5'd0; send_word(w);
        w = base_word(CMD_TICK); w.hour = 5'd8; w.minute = 6'd1; send_word(w);
        w = base_word(CMD_TICK); w.updating = 1; send_word(w);
        w = base_word(CMD_TICK); w.notifier_idle = 0; w.ms = 32'hffff_ffff; send_word(w);
        w = base_word(CMD_TICK); w.dow = 3'd7; w.hour = 5'd31; w.minute = 6'd63; send_word(w);
        w = base_word(CMD_TICK); w.link_ok = 0; send_word(w);
        w = base_word(CMD_FIRST_UNUSED); send_word(w);
        w = base_word(CMD_LAST_UNUSED); send_word(w);
        w = base_word(CMD_CLEAR); send_word(w);
        w = base_word(CMD_QUERY); send_word(w);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: regs = '{1, 7'h7f, 8, 1, 9, 2, 0, 0};
                1: regs = '{0, 0, 8'hff, 8'hff, 8'hff, 8'hff, 1, 16'hffff};
                default: pool_regs(regs);
            endcase
            program_regs(regs);
            idle_pct = idle_set[ph];
            stall_pct = stall_set[ph];
            for (int n = 0; n < 345; n++)
            begin
                // now and then a stretch with no idling and no output stalls
                if (n % 100 == 50)
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                else if (n % 100 == 80)
                begin
                    idle_pct = idle_set[ph];
                    stall_pct = stall_set[ph];
                end
                send_word(random_word());
                if (n == 170)
                    drain();
            end
            drain();
        end

        $display("sent %0d command words, checked %0d status words, %0d alarms fired",
                 sent, sb.checked, sb.fires);
        $display("covered four register settings and four idle/stall mixes, %0d errors",
                 sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
